// File: hw/rtl/ght_pkg.sv
// Shared types and constants for the generational handle table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ght_pkg;

  localparam int unsigned SLOT_COUNT_DEFAULT = 32;
  localparam int unsigned MAX_RESULTS        = 32;
  localparam int unsigned TODO_W             = $clog2(MAX_RESULTS + 1);

  localparam int unsigned HIDX_W = 32;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned PAY_W  = 64;

  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

  typedef enum logic [1:0] {
    KIND_SPAWN   = 2'd0,
    KIND_VIEW    = 2'd1,
    KIND_DESTROY = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_STALE     = 3'd4,
    ST_PENDING   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_EXEC    = 3'd1,
    S_SPAWN   = 3'd2,
    S_FL_SLOT = 3'd3,
    S_FL_EMIT = 3'd4
  } state_e;

  typedef struct packed {
    logic capture;
    logic slot_rd_free;
    logic slot_rd_queue;
    logic exec;
    logic flush_start;
    logic emit;
  } ght_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  spawn_reuse;
    logic  queue_empty;
    logic  out_free;
    logic  todo_last;
  } ght_stat_t;

endpackage

// File: hw/rtl/ght_if.sv
// Valid/ready channel interfaces for the handle table requests and results.
// Depends on ght_pkg for field widths and codes.
interface ght_in_if;
  import ght_pkg::*;

  logic                valid;
  logic                ready;
  kind_e               kind;
  logic [HIDX_W-1:0]   handle_index;
  logic [GEN_W-1:0]    handle_generation;
  logic [PAY_W-1:0]    payload;

  modport source (output valid, kind, handle_index, handle_generation, payload,
                  input ready);
  modport sink   (input valid, kind, handle_index, handle_generation, payload,
                  output ready);
endinterface

interface ght_out_if;
  import ght_pkg::*;

  logic                valid;
  logic                ready;
  status_e             status;
  logic [HIDX_W-1:0]   out_index;
  logic [GEN_W-1:0]    out_generation;
  logic [PAY_W-1:0]    out_payload;
  logic                freed;
  logic                last;

  modport source (output valid, status, out_index, out_generation, out_payload, freed, last,
                  input ready);
  modport sink   (input valid, status, out_index, out_generation, out_payload, freed, last,
                  output ready);
endinterface

// File: hw/rtl/generational_handle_table_core.sv
// Top level of the generational handle table.
// Depends on ght_pkg, ght_if, ght_ctrl and ght_dp.
//
//   Channel   Direction  Carries
//   item_i    in         kind, handle_index, handle_generation, payload
//   result_o  out        status, out_index, out_generation, out_payload, freed, last
//
// View, destroy and spawn into a never-used slot pass through S_EXEC only; a spawn that reuses a
// freed slot also passes S_SPAWN, since the slot number comes from the free stack before its
// generation can be read. A flush releases each slot through S_FL_SLOT and S_FL_EMIT, a
// registered queue read followed by a registered slot read. Reset clears all control
// state at once; no clearing pass is needed. A stalled result holds in the output
// register while the next item is already taken in.
module generational_handle_table_core #(
  parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ght_in_if.sink    item_i,
  ght_out_if.source result_o
);
  import ght_pkg::*;

  ght_cmd_t  cmd;
  ght_stat_t stat;

  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ght_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_kind_i     (item_i.kind),
    .in_index_i    (item_i.handle_index),
    .in_gen_i      (item_i.handle_generation),
    .in_payload_i  (item_i.payload),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_status_o  (result_o.status),
    .out_index_o   (result_o.out_index),
    .out_gen_o     (result_o.out_generation),
    .out_payload_o (result_o.out_payload),
    .out_freed_o   (result_o.freed),
    .out_last_o    (result_o.last)
  );

`ifndef NO_ASSERTIONS
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("A second item was taken while the first was still in work.");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec || cmd.emit |-> stat.out_free)
    else $error("A result was loaded while the result register was still occupied.");

  a_flush_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush_start |-> !stat.queue_empty)
    else $error("A flush walk started on an empty pending queue.");

  a_freed_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.freed |-> result_o.status == ST_OK)
    else $error("A released slot was reported with a failing status.");
`endif

endmodule

// File: hw/rtl/ght_ctrl.sv
// Controller state machine of the handle table.
// Depends on ght_pkg; drives the datapath through ght_cmd_t and reads ght_stat_t.
module ght_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ght_pkg::ght_stat_t stat_i,
  output ght_pkg::ght_cmd_t  cmd_o
);
  import ght_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (stat_i.kind)
          KIND_FLUSH: state_d = stat_i.queue_empty ? S_IDLE : S_FL_SLOT;
          KIND_SPAWN: begin
            if (stat_i.spawn_reuse) begin
              state_d = S_SPAWN;
            end else if (stat_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_SPAWN: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_FL_SLOT: state_d = S_FL_EMIT;
      S_FL_EMIT: begin
        if (stat_i.out_free) state_d = stat_i.todo_last ? S_IDLE : S_FL_SLOT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        case (stat_i.kind)
          KIND_FLUSH: cmd_o.flush_start = !stat_i.queue_empty;
          KIND_SPAWN: begin
            if (stat_i.spawn_reuse) begin
              cmd_o.slot_rd_free = 1'b1;
            end else begin
              cmd_o.exec = stat_i.out_free;
            end
          end
          default: cmd_o.exec = stat_i.out_free;
        endcase
      end
      S_SPAWN:   cmd_o.exec          = stat_i.out_free;
      S_FL_SLOT: cmd_o.slot_rd_queue = 1'b1;
      S_FL_EMIT: cmd_o.emit          = stat_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/ght_dp.sv
// Datapath of the handle table: slot memories, free stack, pending queue,
// handle checks and the result register. Depends on ght_pkg; commanded by ght_ctrl.
module ght_dp #(
  parameter int unsigned SLOT_COUNT = ght_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ght_pkg::kind_e              in_kind_i,
  input  logic [ght_pkg::HIDX_W-1:0]  in_index_i,
  input  logic [ght_pkg::GEN_W-1:0]   in_gen_i,
  input  logic [ght_pkg::PAY_W-1:0]   in_payload_i,
  input  ght_pkg::ght_cmd_t           cmd_i,
  output ght_pkg::ght_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ght_pkg::status_e            out_status_o,
  output logic [ght_pkg::HIDX_W-1:0]  out_index_o,
  output logic [ght_pkg::GEN_W-1:0]   out_gen_o,
  output logic [ght_pkg::PAY_W-1:0]   out_payload_o,
  output logic                        out_freed_o,
  output logic                        out_last_o
);
  import ght_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  logic [PAY_W-1:0] pay_mem   [SLOT_COUNT];
  logic [GEN_W-1:0] gen_mem   [SLOT_COUNT];
  logic [IDX_W-1:0] free_mem  [SLOT_COUNT];
  logic [IDX_W-1:0] queue_mem [SLOT_COUNT];

  kind_e             kind_q;
  logic [HIDX_W-1:0] hidx_q;
  logic [GEN_W-1:0]  hgen_q;
  logic [PAY_W-1:0]  pay_q;

  logic [PAY_W-1:0]  pay_rd_q;
  logic [GEN_W-1:0]  gen_rd_q;
  logic [IDX_W-1:0]  free_rd_q;
  logic [IDX_W-1:0]  queue_rd_q;

  logic [SLOT_COUNT-1:0] alive_q, pend_q;
  logic [CNT_W-1:0]      fc_q, hw_q, qcnt_q;
  logic [IDX_W-1:0]      qhead_q, qtail_q;
  logic [TODO_W-1:0]     todo_q, todo_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [HIDX_W-1:0] out_index_q;
  logic [GEN_W-1:0]  out_gen_q;
  logic [PAY_W-1:0]  out_pay_q;
  logic              out_freed_q, out_last_q;

  logic [IDX_W-1:0] slot_raddr, queue_raddr, qhead_inc, qtail_inc, h, spawn_idx;
  logic [IDX_W-1:0] gen_waddr;
  logic [GEN_W-1:0] gen_wdata;
  logic             slot_ren, queue_ren, gen_we, load;
  logic             hidx_ok, free_room;
  status_e          chk;

  status_e           res_status;
  logic [HIDX_W-1:0] res_index;
  logic [GEN_W-1:0]  res_gen;
  logic [PAY_W-1:0]  res_pay;
  logic              res_freed, res_last;
  logic              spawn_free, spawn_new, enqueue;

  assign h         = hidx_q[IDX_W-1:0];
  assign qhead_inc = (qhead_q == IDX_LAST) ? '0 : qhead_q + 1'b1;
  assign qtail_inc = (qtail_q == IDX_LAST) ? '0 : qtail_q + 1'b1;
  assign free_room = (fc_q != CNT_FULL);
  assign load      = cmd_i.exec || cmd_i.emit;

  always_comb begin
    slot_raddr = in_index_i[IDX_W-1:0];
    if (cmd_i.slot_rd_free) begin
      slot_raddr = free_rd_q;
    end else if (cmd_i.slot_rd_queue) begin
      slot_raddr = queue_rd_q;
    end
  end
  assign slot_ren    = cmd_i.capture || cmd_i.slot_rd_free || cmd_i.slot_rd_queue;
  assign queue_raddr = cmd_i.emit ? qhead_inc : qhead_q;
  assign queue_ren   = cmd_i.capture || cmd_i.emit;

  assign hidx_ok = (hidx_q < HIDX_W'(hw_q));
  always_comb begin
    if (!hidx_ok) begin
      chk = ST_BAD_INDEX;
    end else if (!alive_q[h] || (gen_rd_q != hgen_q)) begin
      chk = ST_STALE;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_index  = hidx_q;
    res_gen    = hgen_q;
    res_pay    = '0;
    res_freed  = 1'b0;
    res_last   = 1'b1;
    spawn_free = 1'b0;
    spawn_new  = 1'b0;
    enqueue    = 1'b0;
    if (cmd_i.emit) begin
      res_index = HIDX_W'(queue_rd_q);
      res_gen   = gen_rd_q;
      res_pay   = pay_rd_q;
      res_freed = 1'b1;
      res_last  = (todo_q == TODO_W'(1));
    end else begin
      case (kind_q)
        KIND_SPAWN: begin
          res_index = '0;
          res_gen   = '0;
          if (pay_q == '0) begin
            res_status = ST_NULL;
          end else if (fc_q != '0) begin
            res_index  = HIDX_W'(free_rd_q);
            res_gen    = gen_rd_q;
            spawn_free = 1'b1;
          end else if (hw_q != CNT_FULL) begin
            res_index = HIDX_W'(hw_q);
            res_gen   = GEN_FIRST;
            spawn_new = 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
        KIND_VIEW: begin
          if (chk != ST_OK) begin
            res_status = chk;
          end else if (pend_q[h]) begin
            res_status = ST_STALE;
          end else begin
            res_pay = pay_rd_q;
          end
        end
        KIND_DESTROY: begin
          if (chk != ST_OK) begin
            res_status = chk;
          end else if (pend_q[h]) begin
            res_status = ST_PENDING;
          end else if (qcnt_q == CNT_FULL) begin
            res_status = ST_FULL;
          end else begin
            enqueue = 1'b1;
          end
        end
        default: begin
          res_last = 1'b1;
        end
      endcase
    end
  end

  assign spawn_idx = spawn_free ? free_rd_q : hw_q[IDX_W-1:0];
  assign gen_we    = (cmd_i.exec && spawn_new) || cmd_i.emit;
  assign gen_waddr = cmd_i.emit ? queue_rd_q : spawn_idx;
  assign gen_wdata = cmd_i.emit ? gen_rd_q + GEN_W'(1) : GEN_FIRST;

  always_comb begin
    todo_d = todo_q;
    if (cmd_i.flush_start) begin
      if (32'(qcnt_q) > MAX_RESULTS) begin
        todo_d = TODO_W'(MAX_RESULTS);
      end else begin
        todo_d = TODO_W'(qcnt_q);
      end
    end else if (cmd_i.emit) begin
      todo_d = todo_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= in_kind_i;
      hidx_q    <= in_index_i;
      hgen_q    <= in_gen_i;
      pay_q     <= in_payload_i;
      free_rd_q <= free_mem[IDX_W'(fc_q - 1'b1)];
    end
    if (slot_ren) begin
      pay_rd_q <= pay_mem[slot_raddr];
      gen_rd_q <= gen_mem[slot_raddr];
    end
    if (queue_ren) begin
      queue_rd_q <= queue_mem[queue_raddr];
    end
    if (cmd_i.exec && (spawn_free || spawn_new)) begin
      pay_mem[spawn_idx] <= pay_q;
    end
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (cmd_i.emit && free_room) begin
      free_mem[fc_q[IDX_W-1:0]] <= queue_rd_q;
    end
    if (cmd_i.exec && enqueue) begin
      queue_mem[qtail_q] <= h;
    end
    if (load) begin
      out_status_q <= res_status;
      out_index_q  <= res_index;
      out_gen_q    <= res_gen;
      out_pay_q    <= res_pay;
      out_freed_q  <= res_freed;
      out_last_q   <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q     <= '0;
      pend_q      <= '0;
      fc_q        <= '0;
      hw_q        <= '0;
      qcnt_q      <= '0;
      qhead_q     <= '0;
      qtail_q     <= '0;
      todo_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      todo_q <= todo_d;
      if (cmd_i.exec && (spawn_free || spawn_new)) begin
        alive_q[spawn_idx] <= 1'b1;
        pend_q[spawn_idx]  <= 1'b0;
      end
      if (cmd_i.exec && spawn_free) begin
        fc_q <= fc_q - 1'b1;
      end
      if (cmd_i.exec && spawn_new) begin
        hw_q <= hw_q + 1'b1;
      end
      if (cmd_i.exec && enqueue) begin
        pend_q[h] <= 1'b1;
        qtail_q   <= qtail_inc;
        qcnt_q    <= qcnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        alive_q[queue_rd_q] <= 1'b0;
        pend_q[queue_rd_q]  <= 1'b0;
        qhead_q             <= qhead_inc;
        qcnt_q              <= qcnt_q - 1'b1;
        if (free_room) begin
          fc_q <= fc_q + 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.kind        = kind_q;
  assign stat_o.spawn_reuse = (kind_q == KIND_SPAWN) && (pay_q != '0) && (fc_q != '0);
  assign stat_o.queue_empty = (qcnt_q == '0);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.todo_last   = (todo_q == TODO_W'(1));

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_index_o   = out_index_q;
  assign out_gen_o     = out_gen_q;
  assign out_payload_o = out_pay_q;
  assign out_freed_o   = out_freed_q;
  assign out_last_o    = out_last_q;

endmodule

// File: dv/handle_table_checker.sv
// Checker for the generational handle table: keeps its own copy of the table,
// predicts the result transfers of every accepted request and compares them.
// Depends on ght_pkg and the channel interfaces in ght_if.
module handle_table_checker #(
  parameter int unsigned SLOTS = ght_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  ght_in_if                                    item_mon,
  ght_out_if                                   result_mon,
  output int                                   fail_count_o,
  output int                                   outstanding_o,
  output int                                   high_water_o,
  output logic [SLOTS-1:0][ght_pkg::GEN_W-1:0] slot_gen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ght_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [HIDX_W-1:0]  index;
    logic [GEN_W-1:0]   generation;
    logic [PAY_W-1:0]   payload;
    logic               freed;
    logic               last;
  } handle_result_t;

  logic [PAY_W-1:0]            stored_pay [SLOTS];
  logic [SLOTS-1:0][GEN_W-1:0] gen_q;
  logic [SLOTS-1:0]            alive_q;
  logic [SLOTS-1:0]            pending_q;
  int                          free_stack [$];
  int                          destroy_q [$];
  int                          high_water = 0;
  handle_result_t              expected_q [$];
  handle_result_t              want;

  assign slot_gen_o = gen_q;

  initial fail_count_o = 0;

  function automatic status_e handle_status(logic [HIDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    if (idx >= high_water) return ST_BAD_INDEX;
    if (!alive_q[idx] || gen_q[idx] != gen) return ST_STALE;
    return ST_OK;
  endfunction

  task automatic add_expected(handle_result_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic compare_field(string name, logic [PAY_W-1:0] exp_v, logic [PAY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic predict_table(kind_e kind, logic [HIDX_W-1:0] idx, logic [GEN_W-1:0] gen,
                               logic [PAY_W-1:0] pay);
    status_e        st;
    int             slot;
    int             n;
    int             cur;
    handle_result_t batch [$];
    case (kind)
      KIND_SPAWN: begin
        if (pay == '0) begin
          add_expected('{ST_NULL, '0, '0, '0, 1'b0, 1'b1});
        end else if (free_stack.size() > 0 || high_water < SLOTS) begin
          if (free_stack.size() > 0) begin
            slot = free_stack[$];
            free_stack.delete(free_stack.size() - 1);
          end else begin
            slot = high_water;
            high_water++;
            gen_q[slot] = GEN_FIRST;
          end
          stored_pay[slot] = pay;
          alive_q[slot] = 1'b1;
          pending_q[slot] = 1'b0;
          add_expected('{ST_OK, HIDX_W'(slot), gen_q[slot], '0, 1'b0, 1'b1});
        end else begin
          add_expected('{ST_FULL, '0, '0, '0, 1'b0, 1'b1});
        end
      end
      KIND_VIEW: begin
        st = handle_status(idx, gen);
        if (st == ST_OK && pending_q[idx]) st = ST_STALE;
        add_expected('{st, idx, gen, (st == ST_OK) ? stored_pay[idx] : '0, 1'b0, 1'b1});
      end
      KIND_DESTROY: begin
        st = handle_status(idx, gen);
        if (st == ST_OK && pending_q[idx]) st = ST_PENDING;
        if (st == ST_OK) begin
          pending_q[idx] = 1'b1;
          destroy_q.insert(destroy_q.size(), int'(idx));
        end
        add_expected('{st, idx, gen, '0, 1'b0, 1'b0 | 1'b1});
      end
      default: begin
        n = 0;
        cur = 0;
        while (cur < destroy_q.size() && n < MAX_RESULTS) begin
          slot = destroy_q[cur];
          cur++;
          if (!pending_q[slot]) continue;
          pending_q[slot] = 1'b0;
          alive_q[slot] = 1'b0;
          batch.insert(batch.size(),
                       '{ST_OK, HIDX_W'(slot), gen_q[slot], stored_pay[slot], 1'b1, 1'b0});
          n++;
          stored_pay[slot] = '0;
          gen_q[slot] = gen_q[slot] + 1'b1;
          if (free_stack.size() < SLOTS) free_stack.insert(free_stack.size(), slot);
        end
        repeat (cur) void'(destroy_q.pop_front());
        if (n > 0) batch[n-1].last = 1'b1;
        foreach (batch[i]) add_expected(batch[i]);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        stored_pay[i] = '0;
        gen_q[i] = GEN_FIRST;
      end
      alive_q = '0;
      pending_q = '0;
      free_stack.delete();
      destroy_q.delete();
      expected_q.delete();
      high_water = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("Result transfer with nothing expected: status %0d, index 0x%0h",
                 result_mon.status, result_mon.out_index);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          compare_field("status", PAY_W'(want.status), PAY_W'(result_mon.status));
          compare_field("out_index", PAY_W'(want.index), PAY_W'(result_mon.out_index));
          compare_field("out_generation", PAY_W'(want.generation),
                        PAY_W'(result_mon.out_generation));
          compare_field("out_payload", want.payload, result_mon.out_payload);
          compare_field("freed", PAY_W'(want.freed), PAY_W'(result_mon.freed));
          compare_field("last", PAY_W'(want.last), PAY_W'(result_mon.last));
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        predict_table(item_mon.kind, item_mon.handle_index, item_mon.handle_generation,
                      item_mon.payload);
      end
    end
    outstanding_o = expected_q.size();
    high_water_o = high_water;
  end

endmodule

// File: dv/testbench.sv
// Top of the handle table testbench: clock, reset, request and result traffic and the verdict.
// Depends on ght_pkg, ght_if, handle_table_checker and generational_handle_table_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ght_pkg::*;

  localparam int unsigned SLOTS = SLOT_COUNT_DEFAULT;
  localparam int RANDOM_ITEMS = 387;

  typedef enum {MODE_FILL, MODE_CHURN, MODE_DRAIN} traffic_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  int                          fail_count;
  int                          outstanding;
  int                          high_water;
  logic [SLOTS-1:0][GEN_W-1:0] slot_gen;
  bit                          send_calm = 1'b0;
  bit                          recv_calm = 1'b0;

  always #4 clk_i = ~clk_i;

  ght_in_if  item_if ();
  ght_out_if result_if ();

  generational_handle_table_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  handle_table_checker #(.SLOTS(SLOTS)) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_mon      (item_if),
    .result_mon    (result_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .high_water_o  (high_water),
    .slot_gen_o    (slot_gen)
  );

  task automatic send_item(kind_e kind, logic [HIDX_W-1:0] idx, logic [GEN_W-1:0] gen,
                           logic [PAY_W-1:0] pay);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid             <= 1'b1;
    item_if.kind              <= kind;
    item_if.handle_index      <= idx;
    item_if.handle_generation <= gen;
    item_if.payload           <= pay;
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic pick_handle(inout logic [HIDX_W-1:0] idx, inout logic [GEN_W-1:0] gen);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && high_water > 0) begin
      idx = $urandom_range(0, high_water - 1);
      gen = slot_gen[idx];
    end else if (r < 90) begin
      idx = $urandom_range(0, SLOTS);
      gen = slot_gen[idx % SLOTS] + $urandom_range(0, 2) - 1;
    end
  endtask

  task automatic send_random(traffic_mode_e mode);
    int                r;
    int                spawn_pct;
    int                view_pct;
    int                destroy_pct;
    kind_e             kind;
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  gen;
    logic [PAY_W-1:0]  pay;
    case (mode)
      MODE_FILL: begin
        spawn_pct = 60; view_pct = 20; destroy_pct = 12;
      end
      MODE_CHURN: begin
        spawn_pct = 25; view_pct = 35; destroy_pct = 25;
      end
      default: begin
        spawn_pct = 5; view_pct = 25; destroy_pct = 65;
      end
    endcase
    idx = $urandom;
    gen = $urandom;
    pay = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < spawn_pct) begin
      kind = KIND_SPAWN;
      if ($urandom_range(0, 29) == 0) pay = '0;
    end else if (r < spawn_pct + view_pct) begin
      kind = KIND_VIEW;
      pick_handle(idx, gen);
    end else if (r < spawn_pct + view_pct + destroy_pct) begin
      kind = KIND_DESTROY;
      pick_handle(idx, gen);
    end else begin
      kind = KIND_FLUSH;
    end
    send_item(kind, idx, gen, pay);
  endtask

  // Result side: a random stall before each transfer, with calm stretches.
  initial begin
    int stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
    end
  end

  initial begin
    traffic_mode_e mode;
    int            sent;
    item_if.valid = 1'b0;
    item_if.kind = KIND_SPAWN;
    item_if.handle_index = '0;
    item_if.handle_generation = '0;
    item_if.payload = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Empty table, null payload, first spawns, handle checks and a two-slot flush.
    send_item(KIND_VIEW, 0, 1, '0);
    send_item(KIND_DESTROY, 0, 1, '1);
    send_item(KIND_FLUSH, '0, '0, '0);
    send_item(KIND_SPAWN, '1, '1, '0);
    send_item(KIND_SPAWN, '0, '0, '1);
    send_item(KIND_SPAWN, '0, '0, 64'h1);
    send_item(KIND_SPAWN, '0, '0, 64'h8000_0000_0000_0000);
    send_item(KIND_VIEW, 0, 1, '0);
    send_item(KIND_VIEW, 0, '1, '0);
    send_item(KIND_VIEW, '1, 1, '0);
    send_item(KIND_VIEW, 3, 1, '0);
    send_item(KIND_DESTROY, 1, 1, '0);
    send_item(KIND_VIEW, 1, 1, '0);
    send_item(KIND_DESTROY, 1, 1, '0);
    send_item(KIND_DESTROY, '1, '1, '0);
    send_item(KIND_DESTROY, 0, 2, '0);
    send_item(KIND_DESTROY, 2, 1, '0);
    send_item(KIND_FLUSH, '1, '1, '1);
    send_item(KIND_VIEW, 1, 1, '0);
    send_item(KIND_DESTROY, 2, 1, '0);
    send_item(KIND_SPAWN, '0, '0, 64'h5555_aaaa_5555_aaaa);
    send_item(KIND_SPAWN, '0, '0, 64'haaaa_5555_aaaa_5555);
    send_item(KIND_VIEW, 2, 2, '0);
    wait_idle();

    sent = 0;
    mode = MODE_FILL;
    while (sent < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 50)) begin
        send_random(mode);
        sent++;
      end
      if (mode == MODE_DRAIN) send_item(KIND_FLUSH, $urandom, $urandom, {$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) wait_idle();
      case (mode)
        MODE_FILL:  mode = MODE_CHURN;
        MODE_CHURN: mode = MODE_DRAIN;
        default:    mode = MODE_FILL;
      endcase
    end

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
